### rtl/rsa_pei_pkg.sv
package rsa_pei_pkg;

    localparam int PRIME_WIDTH    = 16;
    localparam int EXPONENT_WIDTH = 32;
    localparam int PRODUCT_WIDTH  = 2 * PRIME_WIDTH;

    typedef struct packed {
        logic [PRIME_WIDTH-1:0]    prime_p;
        logic [PRIME_WIDTH-1:0]    prime_q;
        logic [EXPONENT_WIDTH-1:0] public_exponent;
    } operands_t;

    typedef struct packed {
        logic [EXPONENT_WIDTH-1:0] private_exponent;
        logic                      inverse_exists;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHI,
        S_DIV_FIRST,
        S_SEED,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_load;
        logic div_first;
        logic div_step;
        logic seed;
        logic update;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic phi_zero;
        logic r1_zero;
        logic count_last;
    } dp_status_t;

endpackage

### rtl/rsa_pei_datapath.sv
module rsa_pei_datapath
    import rsa_pei_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic       clk,
    input  dp_cmd_t    cmd,
    input  operands_t  operands,
    output dp_status_t status,
    output result_t    result
);

    localparam int CW   = W + 2;
    localparam int CNTW = $clog2(W);

    logic [PRIME_WIDTH-1:0]   p_m1;
    logic [PRIME_WIDTH-1:0]   q_m1;
    logic [PRODUCT_WIDTH-1:0] product;
    logic [W-1:0]             phi_w;
    logic [W-1:0]             e_w;

    logic [W-1:0] phi_reg;
    logic [W-1:0] e_reg;
    logic [W-1:0] r0_reg;
    logic [W-1:0] r1_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] quo_reg;
    logic [W-1:0] divisor_reg;
    logic [CNTW-1:0] cnt_reg;
    logic signed [CW-1:0] t0_reg;
    logic signed [CW-1:0] t1_reg;
    logic signed [CW-1:0] acc_reg;
    logic signed [CW-1:0] t_adj;
    result_t result_reg;

    logic [W:0]   rem_shift;
    logic         qbit;
    logic [W-1:0] rem_next;
    logic [31:0]  d32;

    assign p_m1    = (operands.prime_p == '0) ? '0 : operands.prime_p - 1'b1;
    assign q_m1    = (operands.prime_q == '0) ? '0 : operands.prime_q - 1'b1;
    assign product = p_m1 * q_m1;

    generate
        if (W >= PRODUCT_WIDTH) begin : g_phi_wide
            assign phi_w = {{(W - PRODUCT_WIDTH){1'b0}}, product};
        end else begin : g_phi_narrow
            assign phi_w = product[W-1:0];
        end
        if (W >= EXPONENT_WIDTH) begin : g_e_wide
            assign e_w = {{(W - EXPONENT_WIDTH){1'b0}}, operands.public_exponent};
        end else begin : g_e_narrow
            assign e_w = operands.public_exponent[W-1:0];
        end
    endgenerate

    // One restoring division step: the next dividend bit shifts into the
    // partial remainder and the quotient bit falls out of the compare.
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign qbit      = (rem_shift >= {1'b0, divisor_reg});
    assign rem_next  = qbit ? W'(rem_shift - {1'b0, divisor_reg}) : rem_shift[W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            phi_reg <= phi_w;
            e_reg   <= e_w;
        end
    end

    // Divider registers. The quotient times t1 is built MSB first in
    // acc_reg while the quotient bits come out, so no multiplier is needed.
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg     <= '0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            quo_reg     <= cmd.div_first ? e_reg : r0_reg;
            divisor_reg <= cmd.div_first ? phi_reg : r1_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], qbit};
            cnt_reg <= cnt_reg + 1'b1;
            acc_reg <= (acc_reg <<< 1) + (qbit ? t1_reg : CW'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed)
        begin
            r0_reg <= phi_reg;
            r1_reg <= rem_reg;
            t0_reg <= '0;
            t1_reg <= {{(CW-1){1'b0}}, 1'b1};
        end
        else if (cmd.update)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            t0_reg <= t1_reg;
            t1_reg <= t0_reg - acc_reg;
        end
    end

    // The final coefficient lies strictly between -phi and phi, so one
    // conditional add brings it into range.
    assign t_adj = t0_reg[CW-1] ? t0_reg + $signed({2'b00, phi_reg}) : t0_reg;

    generate
        if (W >= 32) begin : g_d_wide
            assign d32 = t_adj[31:0];
        end else begin : g_d_narrow
            assign d32 = {{(32 - W){1'b0}}, t_adj[W-1:0]};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if ((phi_reg != '0) && (r0_reg == W'(1)))
            begin
                result_reg.private_exponent <= d32;
                result_reg.inverse_exists   <= 1'b1;
            end
            else
            begin
                result_reg.private_exponent <= '0;
                result_reg.inverse_exists   <= 1'b0;
            end
        end
    end

    assign result            = result_reg;
    assign status.phi_zero   = (phi_reg == '0);
    assign status.r1_zero    = (r1_reg == '0);
    assign status.count_last = (cnt_reg == CNTW'(W - 1));

endmodule

### rtl/rsa_pei_ctrl.sv
module rsa_pei_ctrl
    import rsa_pei_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PHI;
                end
            end
            S_PHI:
            begin
                state_next = status.phi_zero ? S_FINISH : S_DIV_FIRST;
            end
            S_DIV_FIRST:
            begin
                if (status.count_last)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = status.r1_zero ? S_FINISH : S_DIV;
            end
            S_DIV:
            begin
                if (status.count_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_PHI:
            begin
                cmd.div_load  = !status.phi_zero;
                cmd.div_first = 1'b1;
            end
            S_DIV_FIRST, S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_SEED:
            begin
                cmd.seed = 1'b1;
            end
            S_CHECK:
            begin
                cmd.div_load = !status.r1_zero;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### rtl/rsa_private_exponent_inverse.sv
// Channel   Ports                   Transaction
// -------   ---------------------   ----------------------------------------
// input     start, busy, operands   accepted at a clock edge with start high
//                                   and busy low
// output    done, result            valid for the one cycle that done is high
//
// Each transaction does a first reduction of e by phi, then the Euclid steps,
// each with one division, until the remainder is zero, and then a finish. The
// divider is bit-serial and works on W-bit values (W is MODULUS_WIDTH). When
// no Euclid step is needed the first reduction leads straight to the finish,
// and a zero totient skips the division and finishes directly.
// Reset clears the controller; busy is low and done low after reset.
// The receiver cannot stall: the result is shown once, for one cycle.
module rsa_private_exponent_inverse
    import rsa_pei_pkg::*;
#(
    parameter int MODULUS_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  operands_t operands,
    output logic      done,
    output result_t   result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rsa_pei_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rsa_pei_datapath #(
        .W (MODULUS_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .operands (operands),
        .status   (status),
        .result   (result)
    );

endmodule
